// ----- src/sbt_pkg.sv -----
package sbt_pkg;

   // event kinds
   localparam logic [3:0] KIND_LPAREN   = 4'd0;
   localparam logic [3:0] KIND_RPAREN   = 4'd1;
   localparam logic [3:0] KIND_STR_BYTE = 4'd2;
   localparam logic [3:0] KIND_STR_END  = 4'd3;
   localparam logic [3:0] KIND_ATOM_BYTE = 4'd4;
   localparam logic [3:0] KIND_ATOM_END = 4'd5;
   localparam logic [3:0] KIND_INTEGER  = 4'd6;
   localparam logic [3:0] KIND_DECIMAL  = 4'd7;
   localparam logic [3:0] KIND_ERROR    = 4'd8;
   localparam logic [3:0] KIND_TEXT_END = 4'd9;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_ESCAPE   = 2'd2;
   localparam logic [1:0] ERR_UNTERM   = 2'd3;

   // characters of interest
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam int MAX_EVENTS = 3;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  data;
      logic        neg;
      logic [62:0] mag;
      logic [59:0] frac;
      logic [4:0]  fdig;
      logic [1:0]  err;
   } event_type;

   // events produced by one input word
   typedef struct packed {
      event_type [MAX_EVENTS-1:0] ev;
      logic [1:0]                 count;
   } lex_out_type;

   function automatic event_type mk_event(input logic [3:0] kind, input logic [7:0] data,
                                          input logic neg, input logic [62:0] mag,
                                          input logic [59:0] frac, input logic [4:0] fdig,
                                          input logic [1:0] err);
      event_type e;
      e.kind = kind;
      e.data = data;
      e.neg  = neg;
      e.mag  = mag;
      e.frac = frac;
      e.fdig = fdig;
      e.err  = err;
      return e;
   endfunction

   function automatic event_type simple_event(input logic [3:0] kind, input logic [7:0] data,
                                              input logic [1:0] err);
      return mk_event(kind, data, 1'b0, 63'd0, 60'd0, 5'd0, err);
   endfunction

endpackage

// ----- src/sexpr_byte_tokenizer.sv -----
// Channel  Ports                               Direction
// -------  ----------------------------------  ---------
// req      req_valid/req_stall, in_byte, eot   in
// rsp      rsp_valid/rsp_stall, event fields   out
//
// Each input word is registered, lexed combinationally into zero to three
// events, and the events leave one per cycle, unless rsp_stall holds them,
// from a small event buffer. A word with at most one event sustains one word
// per cycle; a word with more events holds the input until its last leaves.
// Synchronous active-high reset returns the lexer to idle between tokens.
// rsp_stall holds the buffer and, once it is full, backs up into req_stall.
module sexpr_byte_tokenizer #(
   parameter int MAX_FRAC_DIGITS = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_event_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_is_negative,
   output logic [62:0] rsp_int_magnitude,
   output logic [59:0] rsp_frac_value,
   output logic [4:0]  rsp_frac_digits,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last
);

   logic       item_valid_ff, item_valid_in;
   logic [7:0] byte_ff;
   logic       eot_ff;
   logic       buf_ready, consume, accept;

   sbt_pkg::lex_out_type lex_out;
   sbt_pkg::event_type   out_event;

   assign consume   = item_valid_ff && buf_ready;
   assign req_stall = item_valid_ff && !consume;
   assign accept    = req_valid && !req_stall;

   // input word register
   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) item_valid_in = 1'b1;
      else if (consume) item_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) item_valid_ff <= 1'b0;
      else item_valid_ff <= item_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_in_byte;
         eot_ff  <= req_end_of_text;
      end
   end

   sbt_lexer #(
      .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
   ) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .step       (consume),
      .in_byte    (byte_ff),
      .end_of_text(eot_ff),
      .lex_out    (lex_out)
   );

   sbt_evbuf u_evbuf (
      .clock    (clock),
      .reset    (reset),
      .load     (consume),
      .lex_out  (lex_out),
      .ready    (buf_ready),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_event(out_event),
      .out_last (rsp_last)
   );

   assign rsp_event_kind    = out_event.kind;
   assign rsp_data_byte     = out_event.data;
   assign rsp_is_negative   = out_event.neg;
   assign rsp_int_magnitude = out_event.mag;
   assign rsp_frac_value    = out_event.frac;
   assign rsp_frac_digits   = out_event.fdig;
   assign rsp_error_code    = out_event.err;

endmodule

// ----- src/sbt_lexer.sv -----
module sbt_lexer #(
   parameter int MAX_FRAC_DIGITS = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   input  logic                 end_of_text,
   output sbt_pkg::lex_out_type lex_out
);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_STRING  = 3'd2;
   localparam logic [2:0] MODE_ATOM    = 3'd3;
   localparam logic [2:0] MODE_MINUS   = 3'd4;
   localparam logic [2:0] MODE_INT     = 3'd5;
   localparam logic [2:0] MODE_FRAC    = 3'd6;
   localparam logic [2:0] MODE_SKIP    = 3'd7;

   logic [2:0]  mode_ff, mode_in;
   logic        esc_ff, esc_in;
   logic        neg_ff, neg_in;
   logic [62:0] int_ff, int_in;
   logic [59:0] frac_ff, frac_in;
   logic [4:0]  fcnt_ff, fcnt_in;

   logic                  is_numeral, is_blank, is_delim;
   logic [3:0]            digit;
   logic [67:0]           int_ext, int_mul;
   logic                  int_fits;
   logic [59:0]           frac_mul;
   sbt_pkg::event_type    num_ev;
   sbt_pkg::event_type [sbt_pkg::MAX_EVENTS-1:0] ev;
   logic [1:0]            n;
   logic                  do_start, do_atom;

   // byte classes
   assign is_numeral = in_byte inside {[sbt_pkg::CH_ZERO:sbt_pkg::CH_NINE]};
   assign is_blank = in_byte inside {sbt_pkg::CH_SPACE, sbt_pkg::CH_LF, sbt_pkg::CH_TAB};
   assign is_delim = is_blank || in_byte inside {sbt_pkg::CH_LPAREN, sbt_pkg::CH_RPAREN};
   assign digit    = in_byte[3:0];

   // accumulate times ten plus digit; overflow when the result leaves 63 bits
   assign int_ext  = {5'd0, int_ff};
   assign int_mul  = (int_ext << 3) + (int_ext << 1) + 68'(digit);
   assign int_fits = (int_mul[67:63] == 5'd0);
   assign frac_mul = (frac_ff << 3) + (frac_ff << 1) + 60'(digit);

   // closing event of an open number
   always_comb begin
      if (mode_ff == MODE_INT) begin
         num_ev = sbt_pkg::mk_event(sbt_pkg::KIND_INTEGER, 8'd0, neg_ff, int_ff,
                                    60'd0, 5'd0, sbt_pkg::ERR_NONE);
      end else begin
         num_ev = sbt_pkg::mk_event(sbt_pkg::KIND_DECIMAL, 8'd0, neg_ff, int_ff,
                                    frac_ff, fcnt_ff, sbt_pkg::ERR_NONE);
      end
   end

   // next state and event list
   always_comb begin
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      neg_in   = neg_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      fcnt_in  = fcnt_ff;
      ev       = '0;
      n        = 2'd0;
      do_start = 1'b0;
      do_atom  = 1'b0;
      if (end_of_text) begin
         case (mode_ff)
            MODE_ATOM: begin
               ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_ATOM_END, 8'd0, sbt_pkg::ERR_NONE);
               n = n + 2'd1;
            end
            MODE_MINUS: begin
               ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_ATOM_BYTE, sbt_pkg::CH_MINUS,
                                             sbt_pkg::ERR_NONE);
               n = n + 2'd1;
               ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_ATOM_END, 8'd0, sbt_pkg::ERR_NONE);
               n = n + 2'd1;
            end
            MODE_INT, MODE_FRAC: begin
               ev[n] = num_ev;
               n = n + 2'd1;
            end
            MODE_STRING: begin
               ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_ERROR, 8'd0, sbt_pkg::ERR_UNTERM);
               n = n + 2'd1;
            end
            default: begin
            end
         endcase
         ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_TEXT_END, 8'd0, sbt_pkg::ERR_NONE);
         n = n + 2'd1;
         mode_in = MODE_IDLE;
         esc_in  = 1'b0;
         neg_in  = 1'b0;
         int_in  = '0;
         frac_in = '0;
         fcnt_in = '0;
      end else begin
         case (mode_ff)
            MODE_COMMENT: begin
               if (in_byte == sbt_pkg::CH_LF) mode_in = MODE_IDLE;
            end
            MODE_STRING: begin
               if (in_byte == sbt_pkg::CH_QUOTE) begin
                  ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_STR_END, 8'd0, sbt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  esc_in  = 1'b0;
                  mode_in = MODE_IDLE;
               end else if (esc_ff) begin
                  esc_in = 1'b0;
                  if (in_byte == sbt_pkg::CH_BSLASH) begin
                     ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_STR_BYTE, sbt_pkg::CH_BSLASH,
                                                   sbt_pkg::ERR_NONE);
                  end else if (in_byte == sbt_pkg::CH_N) begin
                     ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_STR_BYTE, sbt_pkg::CH_LF,
                                                   sbt_pkg::ERR_NONE);
                  end else begin
                     ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_ERROR, 8'd0,
                                                   sbt_pkg::ERR_ESCAPE);
                  end
                  n = n + 2'd1;
               end else if (in_byte == sbt_pkg::CH_BSLASH) begin
                  esc_in = 1'b1;
               end else begin
                  ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_STR_BYTE, in_byte,
                                                sbt_pkg::ERR_NONE);
                  n = n + 2'd1;
               end
            end
            MODE_ATOM: begin
               do_atom = 1'b1;
            end
            MODE_MINUS: begin
               if (is_numeral) begin
                  mode_in = MODE_INT;
                  neg_in  = 1'b1;
                  int_in  = 63'(digit);
               end else begin
                  ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_ATOM_BYTE, sbt_pkg::CH_MINUS,
                                                sbt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  mode_in = MODE_ATOM;
                  do_atom = 1'b1;
               end
            end
            MODE_INT: begin
               if (is_numeral) begin
                  if (int_fits) begin
                     int_in = int_mul[62:0];
                  end else begin
                     ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_ERROR, 8'd0,
                                                   sbt_pkg::ERR_OVERFLOW);
                     n = n + 2'd1;
                     mode_in = MODE_SKIP;
                  end
               end else if (in_byte == sbt_pkg::CH_DOT) begin
                  mode_in = MODE_FRAC;
                  frac_in = '0;
                  fcnt_in = '0;
               end else begin
                  ev[n] = num_ev;
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (is_numeral) begin
                  if (fcnt_ff < 5'(MAX_FRAC_DIGITS)) begin
                     frac_in = frac_mul;
                     fcnt_in = fcnt_ff + 5'd1;
                  end
               end else begin
                  ev[n] = num_ev;
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_SKIP: begin
               if (!is_numeral && in_byte != sbt_pkg::CH_DOT) do_start = 1'b1;
            end
            default: begin
               do_start = 1'b1;
            end
         endcase

         // byte inside an atom
         if (do_atom) begin
            if (is_delim) begin
               ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_ATOM_END, 8'd0, sbt_pkg::ERR_NONE);
               n = n + 2'd1;
               mode_in = MODE_IDLE;
               if (in_byte == sbt_pkg::CH_LPAREN) begin
                  ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_LPAREN, 8'd0, sbt_pkg::ERR_NONE);
                  n = n + 2'd1;
               end else if (in_byte == sbt_pkg::CH_RPAREN) begin
                  ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_RPAREN, 8'd0, sbt_pkg::ERR_NONE);
                  n = n + 2'd1;
               end
            end else begin
               ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_ATOM_BYTE, in_byte,
                                             sbt_pkg::ERR_NONE);
               n = n + 2'd1;
            end
         end

         // byte at the start of a token
         if (do_start) begin
            mode_in = MODE_IDLE;
            if (is_blank) begin
               mode_in = MODE_IDLE;
            end else if (in_byte == sbt_pkg::CH_SEMI) begin
               mode_in = MODE_COMMENT;
            end else if (in_byte == sbt_pkg::CH_LPAREN) begin
               ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_LPAREN, 8'd0, sbt_pkg::ERR_NONE);
               n = n + 2'd1;
            end else if (in_byte == sbt_pkg::CH_RPAREN) begin
               ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_RPAREN, 8'd0, sbt_pkg::ERR_NONE);
               n = n + 2'd1;
            end else if (in_byte == sbt_pkg::CH_QUOTE) begin
               mode_in = MODE_STRING;
               esc_in  = 1'b0;
            end else if (is_numeral) begin
               mode_in = MODE_INT;
               neg_in  = 1'b0;
               int_in  = 63'(digit);
            end else if (in_byte == sbt_pkg::CH_MINUS) begin
               mode_in = MODE_MINUS;
            end else begin
               mode_in = MODE_ATOM;
               ev[n] = sbt_pkg::simple_event(sbt_pkg::KIND_ATOM_BYTE, in_byte,
                                             sbt_pkg::ERR_NONE);
               n = n + 2'd1;
            end
         end
      end
   end

   assign lex_out.ev    = ev;
   assign lex_out.count = n;

   // lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         esc_ff  <= 1'b0;
         neg_ff  <= 1'b0;
         int_ff  <= '0;
         frac_ff <= '0;
         fcnt_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         neg_ff  <= neg_in;
         int_ff  <= int_in;
         frac_ff <= frac_in;
         fcnt_ff <= fcnt_in;
      end
   end

endmodule

// ----- src/sbt_evbuf.sv -----
module sbt_evbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  sbt_pkg::lex_out_type lex_out,
   output logic                 ready,
   output logic                 out_valid,
   input  logic                 out_stall,
   output sbt_pkg::event_type   out_event,
   output logic                 out_last
);

   sbt_pkg::event_type [sbt_pkg::MAX_EVENTS-1:0] ev_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] rd_ff, rd_in;
   logic       pop;

   assign out_valid = (rd_ff != cnt_ff);
   assign pop       = out_valid && !out_stall;
   assign out_event = ev_ff[rd_ff];
   assign out_last  = (rd_ff == cnt_ff - 2'd1);

   // free for the next word once the last event of this one leaves
   assign ready = !out_valid || (pop && out_last);

   // read pointer and fill count
   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (load) begin
         cnt_in = lex_out.count;
         rd_in  = 2'd0;
      end else if (pop) begin
         rd_in = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

   // event storage
   always_ff @(posedge clock) begin
      if (load) ev_ff <= lex_out.ev;
   end

endmodule
